/* rtl/core/scan_mark_vote_segmenter_defines.svh */
// assertion macros for the scan mark vote segmenter checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef SCAN_MARK_VOTE_SEGMENTER_DEFINES_SVH
`define SCAN_MARK_VOTE_SEGMENTER_DEFINES_SVH

// same-cycle implication, off during reset
`define SMV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segmenter check failed");

// next-cycle implication, off during reset
`define SMV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segmenter check failed");

`endif

/* rtl/core/smv_pkg.sv */
// shared constants, types and helper functions of the scan mark vote segmenter
// no dependencies
package smv_pkg;

    localparam int MAX_POINTS  = 2048;
    localparam int HALF_WINDOW = 5;
    localparam int LAG         = HALF_WINDOW - 1;
    localparam int PNT_W       = $clog2(MAX_POINTS);
    localparam int SEG_W       = 11;
    localparam int ROW_W       = 16;
    localparam int THR_W       = 12;
    localparam int FRAC_W      = 4;
    localparam int SET_ABOVE   = 6;
    localparam int CLEAR_BELOW = 4;
    localparam int CNT_W       = $clog2(2 * HALF_WINDOW + 1);
    localparam int NUM_SLOTS   = HALF_WINDOW + 1;
    localparam int N_W         = $clog2(NUM_SLOTS + 1);
    localparam int TDATA_W     = ((2 * SEG_W + 7) / 8) * 8;

    typedef struct packed {
        logic [HALF_WINDOW-1:0] raw;
        logic [HALF_WINDOW-1:0] sb;
        logic                   in_run;
        logic [PNT_W-1:0]       run_begin;
    } t_win;

    typedef struct packed {
        logic             has_segment;
        logic [SEG_W-1:0] seg_start;
        logic [SEG_W-1:0] seg_end;
        logic             scan_done;
    } t_result;

    typedef struct packed {
        t_win    win;
        logic    emit;
        t_result res;
    } t_smooth;

    typedef struct packed {
        t_result [NUM_SLOTS-1:0] res;
        logic [N_W-1:0]          cnt;
    } t_batch;

    function automatic logic [HALF_WINDOW-1:0] shift_in(logic [HALF_WINDOW-1:0] v, logic b);
        return (v >> 1) | (HALF_WINDOW'(b) << (HALF_WINDOW - 1));
    endfunction

    function automatic t_smooth smooth_point(t_win w, logic [PNT_W-1:0] q);
        t_smooth          s;
        logic [CNT_W-1:0] cnt;
        logic             m;
        cnt = '0;
        for (int k = 0; k < HALF_WINDOW; k++) begin
            cnt = cnt + CNT_W'(w.raw[k]) + CNT_W'(w.sb[k]);
        end
        if (cnt > CNT_W'(SET_ABOVE)) begin
            m = 1'b1;
        end else if (cnt < CNT_W'(CLEAR_BELOW)) begin
            m = 1'b0;
        end else begin
            m = w.raw[0];
        end
        s.win    = w;
        s.win.sb = shift_in(w.sb, m);
        s.emit   = 1'b0;
        s.res    = '0;
        if (m && !w.in_run) begin
            s.win.in_run    = 1'b1;
            s.win.run_begin = q;
        end else if (!m && w.in_run) begin
            s.emit            = 1'b1;
            s.res.has_segment = 1'b1;
            s.res.seg_start   = SEG_W'(w.run_begin);
            s.res.seg_end     = SEG_W'(q - PNT_W'(1));
            s.win.in_run      = 1'b0;
        end
        return s;
    endfunction

    function automatic t_batch push(t_batch b, t_result r);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (N_W'(i) == b.cnt) begin
                b.res[i] = r;
            end
        end
        b.cnt = b.cnt + N_W'(1);
        return b;
    endfunction

    function automatic t_batch mark_done(t_batch b);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (N_W'(i + 1) == b.cnt) begin
                b.res[i].scan_done = 1'b1;
            end
        end
        return b;
    endfunction

endpackage

/* rtl/core/smv_core.sv */
// window state and per-point vote logic, gives the results of one beat
// depends on smv_pkg
module smv_core
    import smv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [ROW_W-1:0] i_row_pos,
    input  logic             i_scan_end,
    input  logic [THR_W-1:0] i_row_threshold,
    output t_batch           o_batch
);

    t_win             r_win;
    t_win             n_win;
    logic [PNT_W-1:0] r_point_index;
    logic [PNT_W-1:0] n_point_index;

    t_win             w;
    t_smooth          s;
    t_batch           b;
    logic             last;
    logic             mark;
    logic [PNT_W:0]   pk;

    assign mark = i_row_pos > ROW_W'({i_row_threshold, FRAC_W'(0)});

    always_comb begin
        b             = '0;
        s             = '0;
        pk            = '0;
        last          = i_scan_end || (r_point_index >= PNT_W'(MAX_POINTS - 1));
        w             = r_win;
        w.raw         = shift_in(w.raw, mark);
        for (int k = 0; k <= LAG; k++) begin
            if (k == 0 || last) begin
                if (k > 0) begin
                    w.raw = shift_in(w.raw, 1'b0);
                end
                pk = (PNT_W+1)'(r_point_index) + (PNT_W+1)'(k);
                if (pk >= (PNT_W+1)'(LAG)) begin
                    s = smooth_point(w, PNT_W'(pk - (PNT_W+1)'(LAG)));
                    w = s.win;
                    if (s.emit) begin
                        b = push(b, s.res);
                    end
                end
            end
        end
        if (last) begin
            if (w.in_run) begin
                b = push(b, t_result'{has_segment: 1'b1,
                                      seg_start:   SEG_W'(w.run_begin),
                                      seg_end:     SEG_W'(r_point_index),
                                      scan_done:   1'b0});
            end
            if (b.cnt != '0) begin
                b = mark_done(b);
            end else begin
                b = push(b, t_result'{has_segment: 1'b0,
                                      seg_start:   '0,
                                      seg_end:     '0,
                                      scan_done:   1'b1});
            end
            n_win         = '0;
            n_point_index = '0;
        end else begin
            n_win         = w;
            n_point_index = r_point_index + PNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win         <= '0;
            r_point_index <= '0;
        end else if (i_fire) begin
            r_win         <= n_win;
            r_point_index <= n_point_index;
        end
    end

    assign o_batch = b;

endmodule

/* rtl/core/scan_mark_vote_segmenter.sv */
// top level of the scan mark vote segmenter: stream ports, threshold register,
// result buffer; depends on smv_pkg and smv_core
//
// One scan point is taken per beat and its results are registered into the
// result buffer; mid-scan a point gives at most one segment, so points stream
// at one per cycle while the consumer keeps up. Segments appear four points
// after the point that closes them. The last point of a scan (tlast, or the
// point with index MAX_POINTS-1) flushes the window and can give several
// results at once; these sit in the result buffer and leave one per cycle
// while the consumer takes them, and the input is held off while more than
// one of them waits. A scan without segments ends with one empty result
// (tuser low). The user must write the threshold through i_cfg_we and
// i_cfg_wdata while the block is idle; the block itself does not enforce it.
module scan_mark_vote_segmenter
    import smv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [ROW_W-1:0]   s_axis_tdata,   // row_pos
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // seg_start, seg_end, zero pad
    output logic               m_axis_tuser,   // has_segment
    output logic               m_axis_tlast
);

    logic [THR_W-1:0]        r_row_threshold;
    t_batch                  w_batch;
    t_result [NUM_SLOTS-1:0] r_buf;
    logic [N_W-1:0]          r_left;
    logic                    fire;
    logic                    take;

    assign take          = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_left == '0) || (r_left == N_W'(1) && m_axis_tready);
    assign fire          = s_axis_tvalid && s_axis_tready;

    smv_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_row_pos       (s_axis_tdata),
        .i_scan_end      (s_axis_tlast),
        .i_row_threshold (r_row_threshold),
        .o_batch         (w_batch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_threshold <= '0;
        end else if (i_cfg_we) begin
            r_row_threshold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (fire) begin
            r_left <= w_batch.cnt;
        end else if (take) begin
            r_left <= r_left - N_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_buf <= w_batch.res;
        end else if (take) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    assign m_axis_tvalid = r_left != '0;
    assign m_axis_tdata  = TDATA_W'({r_buf[0].seg_end, r_buf[0].seg_start});
    assign m_axis_tuser  = r_buf[0].has_segment;
    assign m_axis_tlast  = r_buf[0].scan_done;

endmodule

/* rtl/core/smv_checker.sv */
// port-level checks of the scan mark vote segmenter, bound to the top level
// depends on smv_pkg and scan_mark_vote_segmenter_defines.svh
`include "scan_mark_vote_segmenter_defines.svh"

module smv_checker
    import smv_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    `SMV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `SMV_ASSERT_IMPL(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `SMV_ASSERT_IMPL(a_empty_marker, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0))
    `SMV_ASSERT_IMPL(a_seg_order, m_axis_tvalid && m_axis_tuser, m_axis_tdata[SEG_W-1:0] <= m_axis_tdata[2*SEG_W-1:SEG_W])

endmodule

bind scan_mark_vote_segmenter smv_checker u_smv_checker (.*);
